// ===== rtl/crwm_pkg.sv =====
// Shared types and constants for the clock rate window monitor.
package crwm_pkg;

	localparam int ELAPSED_W        = 32;
	localparam int XTAL_W           = 25;
	localparam int XTAL_MHZ_W       = 7;
	localparam int RATE_W           = 32;
	localparam int ENTRY_W          = 16;
	localparam int FILL_OUT_W       = 9;
	localparam int PROD_W           = ELAPSED_W + XTAL_MHZ_W;
	localparam int WINDOW_DEPTH_DEF = 256;

	localparam logic [XTAL_MHZ_W-1:0] XTAL_MHZ_RST = XTAL_MHZ_W'(40);

	typedef struct packed {
		logic [ELAPSED_W-1:0] elapsed_cpu_cycles;
		logic [XTAL_W-1:0]    xtal_cycles;
		logic                 timed_out;
	} in_item_t;

	typedef struct packed {
		logic                  accepted;
		logic [RATE_W-1:0]     current_mhz;
		logic [ENTRY_W-1:0]    window_high_mhz;
		logic [RATE_W-1:0]     window_low_mhz;
		logic [FILL_OUT_W-1:0] window_fill;
	} out_item_t;

endpackage

// ===== rtl/crwm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module crwm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/crwm_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
module crwm_div #(
	parameter int DVD_W = 39,
	parameter int DVS_W = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	// The partial remainder shifted left by one with the next dividend bit.
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = (trial >= {1'b0, divisor});
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/clock_rate_window_monitor_top.sv =====
// Top level of the clock rate window monitor: sequencer, state and window scan.
//
// Each input item is one calibration measurement. The block computes the CPU
// rate in MHz as floor(elapsed_cpu_cycles * xtal_mhz / xtal_cycles) exactly,
// saturating at 2^32-1, and emits one result item per input item. A sample
// that timed out, has a zero crystal count or yields a zero rate leaves all
// state alone and is reported with accepted low. A usable sample becomes the
// current rate, its low 16 bits are written into a ring window of
// WINDOW_DEPTH entries, and the window's high and low are rescanned over the
// filled entries. A usable sample passes a multiply, then the divider, which
// retires one quotient bit per cycle over 39 bits, then a window write and
// the scan, which reads the window RAM one entry per cycle through its
// single read port. A sample is rejected either before the division or
// after it, when the quotient is zero.
// in_ready is high only while the sequencer is idle, but the finished result
// sits in an output register, so the next item is taken while it waits.
// xtal_mhz resets to 40 and may be rewritten only while the block is idle.
// The window RAM is not cleared; only entries below the fill count are read.
module clock_rate_window_monitor_top #(
	parameter int WINDOW_DEPTH = crwm_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [crwm_pkg::XTAL_MHZ_W-1:0]     cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  crwm_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output crwm_pkg::out_item_t                 out_data
);

	import crwm_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int FW = $clog2(WINDOW_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_START,
		S_DIV,
		S_WRITE,
		S_SCAN,
		S_TAIL,
		S_OUT
	} state_t;

	state_t                state_q;
	logic [XTAL_MHZ_W-1:0] xtal_mhz_q;
	in_item_t              in_q;
	logic [PROD_W-1:0]     prod_q;
	logic [RATE_W-1:0]     current_q;
	logic [ENTRY_W-1:0]    high_q;
	logic [RATE_W-1:0]     low_q;
	logic [FW-1:0]         fill_q;
	logic [AW-1:0]         slot_q;
	logic [AW-1:0]         scan_q;
	logic                  acc_q;
	logic                  out_valid_q;
	out_item_t             res_q;

	logic                  div_start;
	logic                  div_done;
	logic [PROD_W-1:0]     div_quo;
	logic [RATE_W-1:0]     rate_sat;
	logic                  ram_we;
	logic                  ram_re;
	logic [ENTRY_W-1:0]    ram_rdata;
	logic [AW-1:0]         last_idx;
	logic                  load_out;

	// The divider runs on the registered product and the captured crystal count.
	crwm_div #(
		.DVD_W(PROD_W),
		.DVS_W(XTAL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (in_q.xtal_cycles),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Window storage: written once per usable sample, read once per scan step.
	crwm_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (current_q[ENTRY_W-1:0]),
		.re    (ram_re),
		.raddr (scan_q),
		.rdata (ram_rdata)
	);

	assign div_start = (state_q == S_START);
	assign ram_we    = (state_q == S_WRITE);
	assign ram_re    = (state_q == S_SCAN);
	assign in_ready  = (state_q == S_IDLE);
	assign load_out  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// A quotient wider than 32 bits saturates to all ones.
	assign rate_sat = (|div_quo[PROD_W-1:RATE_W]) ? '1 : div_quo[RATE_W-1:0];

	// The fill count is at least one during a scan, so this never wraps.
	assign last_idx = AW'(fill_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xtal_mhz_q <= XTAL_MHZ_RST;
		end else if (cfg_we) begin
			xtal_mhz_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			current_q   <= '0;
			high_q      <= '0;
			low_q       <= '1;
			fill_q      <= '0;
			slot_q      <= '0;
			scan_q      <= '0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the old one in the same cycle it is taken.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						acc_q <= 1'b0;
						if (in_data.timed_out || (in_data.xtal_cycles == '0)) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (div_quo == '0) begin
							state_q <= S_OUT;
						end else begin
							current_q <= rate_sat;
							acc_q     <= 1'b1;
							state_q   <= S_WRITE;
						end
					end
				end
				S_WRITE: begin
					slot_q <= (slot_q == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
					if (fill_q != FW'(WINDOW_DEPTH)) begin
						fill_q <= fill_q + 1'b1;
					end
					high_q  <= '0;
					low_q   <= '1;
					scan_q  <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// Read data is registered and belongs to the previous address; the first step has none.
					if (scan_q != '0) begin
						if (ram_rdata > high_q) begin
							high_q <= ram_rdata;
						end
						if (RATE_W'(ram_rdata) < low_q) begin
							low_q <= RATE_W'(ram_rdata);
						end
					end
					if (scan_q == last_idx) begin
						state_q <= S_TAIL;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_TAIL: begin
					if (ram_rdata > high_q) begin
						high_q <= ram_rdata;
					end
					if (RATE_W'(ram_rdata) < low_q) begin
						low_q <= RATE_W'(ram_rdata);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Captured item, product and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q <= in_data;
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(in_q.elapsed_cpu_cycles) * PROD_W'(xtal_mhz_q);
		end
		if (load_out) begin
			res_q.accepted        <= acc_q;
			res_q.current_mhz     <= current_q;
			res_q.window_high_mhz <= high_q;
			res_q.window_low_mhz  <= low_q;
			res_q.window_fill     <= FILL_OUT_W'(fill_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	// The fill count never passes the window depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(WINDOW_DEPTH))
		else $error("window fill count exceeds depth");

	// A result reporting an accepted sample implies a non-empty window.
	a_acc_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.accepted |-> fill_q != '0)
		else $error("accepted result with empty window");

	// After a scan the low never exceeds the high.
	a_low_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.accepted |->
		out_data.window_low_mhz <= RATE_W'(out_data.window_high_mhz))
		else $error("window low above window high");

	// The divider only finishes while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

endmodule
